>>> hw/rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Shared constants for the sorted multiset difference block: default sizes,
// port field widths and the request mode codes.
// ----------------------------------------------------------------------------
package smd_pkg;

  // Default list capacity and id width
  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned ID_WIDTH_DEF = 64;

  // Port field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned RESULT_W = 64;
  localparam int unsigned TOTAL_W  = 6;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

endpackage

>>> hw/rtl/sorted_multiset_difference_top.sv
// ----------------------------------------------------------------------------
// sorted_multiset_difference_top
// Loads two lists of ids, then on a run request sorts both in place and
// streams the ids of the first list not matched in the second (multiset
// rules) in ascending order. Both lists are emptied after each run.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  request   start_i && !busy_o        mode_i, id_value_i
//  result    valid_o (one-cycle strobe) result_id_o, is_last_o, is_empty_o,
//                                       total_count_o, overflowed_o
//
//  A load request is taken while idle; busy_o stays low. A run request holds busy_o
//  while one shared comparator insertion-sorts each list, one step per cycle,
//  then walks the merge twice (count, then emit), each step passing through a
//  fetch state and a compare state.
//  Reset needs no clearing pass; only entries below the counts are used.
//  Results cannot be stalled: each strobe lasts one cycle.
// ----------------------------------------------------------------------------
module sorted_multiset_difference_top #(
  parameter int unsigned CAPACITY = smd_pkg::CAPACITY_DEF,
  parameter int unsigned ID_WIDTH = smd_pkg::ID_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [smd_pkg::MODE_W-1:0]    mode_i,
  input  logic [smd_pkg::RESULT_W-1:0]  id_value_i,
  output logic                          valid_o,
  output logic [smd_pkg::RESULT_W-1:0]  result_id_o,
  output logic                          is_last_o,
  output logic                          is_empty_o,
  output logic [smd_pkg::TOTAL_W-1:0]   total_count_o,
  output logic                          overflowed_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned RW = smd_pkg::RESULT_W;
  localparam int unsigned TW = smd_pkg::TOTAL_W;

  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C  = CW'(1);
  localparam logic [CW-1:0] TWO_C  = CW'(2);
  localparam logic [CW-1:0] ZERO_C = '0;

  // Sequencer states
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE      = 3'd0;
  localparam logic [ST_W-1:0] ST_SORT_NEXT = 3'd1;
  localparam logic [ST_W-1:0] ST_RD_V      = 3'd2;
  localparam logic [ST_W-1:0] ST_LD_V      = 3'd3;
  localparam logic [ST_W-1:0] ST_CMP       = 3'd4;
  localparam logic [ST_W-1:0] ST_PUT       = 3'd5;
  localparam logic [ST_W-1:0] ST_MRD       = 3'd6;
  localparam logic [ST_W-1:0] ST_MCMP      = 3'd7;

  logic [ST_W-1:0]     state_q, state_d;
  logic                sel_q, sel_d;
  logic                emit_q, emit_d;
  logic                ovf_q, ovf_d;
  logic [CW-1:0]       cnt_a_q, cnt_a_d;
  logic [CW-1:0]       cnt_b_q, cnt_b_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       j_q, j_d;
  logic [CW-1:0]       k_q, k_d;
  logic [CW-1:0]       total_q, total_d;
  logic [ID_WIDTH-1:0] v_q, v_d;

  // Storage and its ports
  logic [ID_WIDTH-1:0] mem_a [CAPACITY];
  logic [ID_WIDTH-1:0] mem_b [CAPACITY];
  logic [ID_WIDTH-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]       rd_addr_a, rd_addr_b;
  logic [AW-1:0]       wr_addr;
  logic [ID_WIDTH-1:0] wr_data;
  logic                we_a, we_b;
  logic                load_a, load_b, sort_we;
  logic [CW-1:0]       sort_ptr;

  // Shared comparator
  logic [ID_WIDTH-1:0] rd_sel, op_x, op_y;
  logic                cmp_lt, cmp_gt;
  logic [CW-1:0]       n_sel;

  // Result staging
  logic                out_valid_d;
  logic [ID_WIDTH-1:0] out_id_d;
  logic                out_last_d, out_empty_d;
  logic [CW-1:0]       out_total_d;
  logic                valid_q;
  logic [RW-1:0]       result_id_q;
  logic                is_last_q, is_empty_q, ovf_out_q;
  logic [TW-1:0]       total_out_q;

  assign rd_sel = sel_q ? rd_b_q : rd_a_q;
  assign n_sel  = sel_q ? cnt_b_q : cnt_a_q;

  // Compare either sort operands or the two merge heads
  assign op_x   = (state_q == ST_MCMP) ? rd_a_q : rd_sel;
  assign op_y   = (state_q == ST_MCMP) ? rd_b_q : v_q;
  assign cmp_lt = op_x < op_y;
  assign cmp_gt = op_x > op_y;

  // Pick the sort read pointer
  always_comb begin
    unique case (state_q)
      ST_RD_V: sort_ptr = i_q;
      ST_LD_V: sort_ptr = i_q - ONE_C;
      default: sort_ptr = j_q - TWO_C;
    endcase
  end

  assign rd_addr_a = (state_q == ST_MRD) ? i_q[AW-1:0] : sort_ptr[AW-1:0];
  assign rd_addr_b = (state_q == ST_MRD) ? j_q[AW-1:0] : sort_ptr[AW-1:0];
  assign we_a      = load_a || (sort_we && !sel_q);
  assign we_b      = load_b || (sort_we && sel_q);

  // Write and read both lists
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_a_q <= mem_a[rd_addr_a];
    rd_b_q <= mem_b[rd_addr_b];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    emit_d      = emit_q;
    ovf_d       = ovf_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    total_d     = total_q;
    v_d         = v_q;
    load_a      = 1'b0;
    load_b      = 1'b0;
    sort_we     = 1'b0;
    wr_addr     = j_q[AW-1:0];
    wr_data     = v_q;
    out_valid_d = 1'b0;
    out_id_d    = rd_a_q;
    out_last_d  = 1'b0;
    out_empty_d = 1'b0;
    out_total_d = ZERO_C;

    unique case (state_q)
      ST_IDLE: begin
        wr_data = id_value_i[ID_WIDTH-1:0];
        wr_addr = (mode_i == smd_pkg::MODE_LOAD_B) ? cnt_b_q[AW-1:0] : cnt_a_q[AW-1:0];
        if (start_i) begin
          unique case (mode_i)
            smd_pkg::MODE_LOAD_A: begin
              if (cnt_a_q < CAP_C) begin
                load_a  = 1'b1;
                cnt_a_d = cnt_a_q + ONE_C;
              end else begin
                ovf_d = 1'b1;
              end
            end
            smd_pkg::MODE_LOAD_B: begin
              if (cnt_b_q < CAP_C) begin
                load_b  = 1'b1;
                cnt_b_d = cnt_b_q + ONE_C;
              end else begin
                ovf_d = 1'b1;
              end
            end
            smd_pkg::MODE_RUN: begin
              sel_d   = 1'b0;
              i_d     = ONE_C;
              state_d = ST_SORT_NEXT;
            end
            default: begin
              // unused mode: drop the request
            end
          endcase
        end
      end

      // Insert the next entry, move to the second list, or start merging
      ST_SORT_NEXT: begin
        if (i_q < n_sel) begin
          state_d = ST_RD_V;
        end else if (!sel_q) begin
          sel_d = 1'b1;
          i_d   = ONE_C;
        end else begin
          i_d     = ZERO_C;
          j_d     = ZERO_C;
          k_d     = ZERO_C;
          total_d = ZERO_C;
          emit_d  = 1'b0;
          state_d = ST_MRD;
        end
      end

      ST_RD_V: begin
        state_d = ST_LD_V;
      end

      // Hold the entry being inserted, fetch its left neighbor
      ST_LD_V: begin
        v_d     = rd_sel;
        j_d     = i_q;
        state_d = ST_CMP;
      end

      // Shift a larger neighbor right, or drop the entry into its hole
      ST_CMP: begin
        sort_we = 1'b1;
        if (cmp_gt) begin
          wr_data = rd_sel;
          if (j_q == ONE_C) begin
            j_d     = ZERO_C;
            state_d = ST_PUT;
          end else begin
            j_d = j_q - ONE_C;
          end
        end else begin
          i_d     = i_q + ONE_C;
          state_d = ST_SORT_NEXT;
        end
      end

      ST_PUT: begin
        sort_we = 1'b1;
        wr_addr = '0;
        i_d     = i_q + ONE_C;
        state_d = ST_SORT_NEXT;
      end

      // Fetch both merge heads, or close a pass
      ST_MRD: begin
        if (i_q < cnt_a_q) begin
          state_d = ST_MCMP;
        end else if (!emit_q && (total_q != ZERO_C)) begin
          emit_d = 1'b1;
          i_d    = ZERO_C;
          j_d    = ZERO_C;
          k_d    = ZERO_C;
        end else begin
          if (!emit_q) begin
            out_valid_d = 1'b1;
            out_id_d    = '0;
            out_last_d  = 1'b1;
            out_empty_d = 1'b1;
          end
          cnt_a_d = ZERO_C;
          cnt_b_d = ZERO_C;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end

      // Advance the merge; count or emit unmatched first-list ids
      ST_MCMP: begin
        state_d = ST_MRD;
        if ((j_q >= cnt_b_q) || cmp_lt) begin
          i_d = i_q + ONE_C;
          if (emit_q) begin
            out_valid_d = 1'b1;
            out_last_d  = ((k_q + ONE_C) == total_q);
            out_total_d = out_last_d ? total_q : ZERO_C;
            k_d         = k_q + ONE_C;
          end else begin
            total_d = total_q + ONE_C;
          end
        end else if (cmp_gt) begin
          j_d = j_q + ONE_C;
        end else begin
          i_d = i_q + ONE_C;
          j_d = j_q + ONE_C;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 1'b0;
      emit_q  <= 1'b0;
      ovf_q   <= 1'b0;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      total_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      emit_q  <= emit_d;
      ovf_q   <= ovf_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      total_q <= total_d;
      valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (out_valid_d) begin
      result_id_q <= RW'(out_id_d);
      is_last_q   <= out_last_d;
      is_empty_q  <= out_empty_d;
      total_out_q <= TW'(out_total_d);
      ovf_out_q   <= ovf_q;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign result_id_o   = result_id_q;
  assign is_last_o     = is_last_q;
  assign is_empty_o    = is_empty_q;
  assign total_count_o = total_out_q;
  assign overflowed_o  = ovf_out_q;

endmodule

>>> hw/rtl/smd_checker.sv
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks of the sorted multiset difference block, bound to the
// top level.
// ----------------------------------------------------------------------------
module smd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [smd_pkg::MODE_W-1:0]    mode_i,
  input logic                          valid_o,
  input logic [smd_pkg::RESULT_W-1:0]  result_id_o,
  input logic                          is_last_o,
  input logic                          is_empty_o,
  input logic [smd_pkg::TOTAL_W-1:0]   total_count_o
);

  // A run request occupies the block on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i == smd_pkg::MODE_RUN)) |=> busy_o)
    else $error("run request did not raise busy");

  // A load or unused request leaves the block free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (mode_i != smd_pkg::MODE_RUN)) |=> !busy_o)
    else $error("load request raised busy");

  // Results only come out of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result strobe outside a run");

  // An empty result is the single, final, zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_empty_o) |-> (is_last_o && (result_id_o == '0) &&
                                 (total_count_o == '0)))
    else $error("malformed empty result");

  // The count rides only on the last result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !is_last_o) |-> (total_count_o == '0))
    else $error("count on a non-final result");

endmodule

bind sorted_multiset_difference_top smd_checker u_smd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .mode_i        (mode_i),
  .valid_o       (valid_o),
  .result_id_o   (result_id_o),
  .is_last_o     (is_last_o),
  .is_empty_o    (is_empty_o),
  .total_count_o (total_count_o)
);

>>> tb/tb_sorted_multiset_difference_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_multiset_difference_top
// Loads two id lists through the request port, issues run requests and
// checks every result strobe against a model of the multiset difference that
// is built from the accepted requests. Directed cases open the run, then
// random list pairs with random content, under changing sender idle rates.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_difference_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smd_pkg::*;

  localparam int unsigned       LIST_DEPTH   = CAPACITY_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam int unsigned       MAX_REPORTS  = 10;
  localparam int unsigned       CYCLE_LIMIT  = 2000000;
  localparam int unsigned       RANDOM_ITEMS = 260;
  localparam int unsigned       DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [RESULT_W-1:0] id;
    logic                last;
    logic                empty;
    logic [TOTAL_W-1:0]  total;
    logic                ovf;
  } diff_result_t;

  // Tracks both lists and the overflow flag, and queues the expected ids
  class difference_tracker;
    logic [RESULT_W-1:0] first_ids[$];
    logic [RESULT_W-1:0] second_ids[$];
    logic                overflow_seen;
    diff_result_t        pending_diff[$];
    int unsigned         failures;

    function new();
      overflow_seen = 1'b0;
      failures      = 0;
    endfunction

    // Apply one accepted request and queue the results it must produce
    function void note_request(logic [MODE_W-1:0] mode, logic [RESULT_W-1:0] id);
      logic [RESULT_W-1:0] a_sorted[$];
      logic [RESULT_W-1:0] b_sorted[$];
      logic [RESULT_W-1:0] diff_ids[$];
      diff_result_t        res;
      int                  i;
      int                  j;
      case (mode)
        MODE_LOAD_A: begin
          if (first_ids.size() < LIST_DEPTH) first_ids.push_back(id);
          else overflow_seen = 1'b1;
        end
        MODE_LOAD_B: begin
          if (second_ids.size() < LIST_DEPTH) second_ids.push_back(id);
          else overflow_seen = 1'b1;
        end
        MODE_RUN: begin
          a_sorted = first_ids;
          b_sorted = second_ids;
          a_sorted.sort();
          b_sorted.sort();
          // Walk both sorted lists; a matched pair cancels one copy each
          i = 0;
          j = 0;
          while (i < a_sorted.size()) begin
            if (j >= b_sorted.size() || a_sorted[i] < b_sorted[j]) begin
              diff_ids.push_back(a_sorted[i]);
              i++;
            end else if (b_sorted[j] < a_sorted[i]) begin
              j++;
            end else begin
              i++;
              j++;
            end
          end
          if (diff_ids.size() == 0) begin
            res = '{id: '0, last: 1'b1, empty: 1'b1, total: '0, ovf: overflow_seen};
            pending_diff.push_back(res);
          end else begin
            foreach (diff_ids[k]) begin
              res.id    = diff_ids[k];
              res.last  = (k == diff_ids.size() - 1);
              res.empty = 1'b0;
              res.total = res.last ? TOTAL_W'(diff_ids.size()) : '0;
              res.ovf   = overflow_seen;
              pending_diff.push_back(res);
            end
          end
          first_ids.delete();
          second_ids.delete();
          overflow_seen = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Compare one result strobe with the oldest expected result
    function void check_result(diff_result_t got);
      diff_result_t want;
      if (pending_diff.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("[%0t] unexpected result: id %h last %b empty %b total %0d ovf %b",
                   $realtime, got.id, got.last, got.empty, got.total, got.ovf);
      end else begin
        want = pending_diff.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("[%0t] result mismatch", $realtime);
            $display("  expected: id %h last %b empty %b total %0d ovf %b",
                     want.id, want.last, want.empty, want.total, want.ovf);
            $display("  actual:   id %h last %b empty %b total %0d ovf %b",
                     got.id, got.last, got.empty, got.total, got.ovf);
          end
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [MODE_W-1:0]   mode_i;
  logic [RESULT_W-1:0] id_value_i;
  logic                valid_o;
  logic [RESULT_W-1:0] result_id_o;
  logic                is_last_o;
  logic                is_empty_o;
  logic [TOTAL_W-1:0]  total_count_o;
  logic                overflowed_o;

  difference_tracker tracker;
  int unsigned       idle_pct;
  int unsigned       items_sent;
  int unsigned       cycle_count;

  sorted_multiset_difference_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .id_value_i    (id_value_i),
    .valid_o       (valid_o),
    .result_id_o   (result_id_o),
    .is_last_o     (is_last_o),
    .is_empty_o    (is_empty_o),
    .total_count_o (total_count_o),
    .overflowed_o  (overflowed_o)
  );

  // Clock: 4 ns period
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Check every result strobe
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      tracker.check_result(diff_result_t'({result_id_o, is_last_o, is_empty_o,
                                           total_count_o, overflowed_o}));
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drop start, with junk on the payload
  task automatic idle_cycle();
    @(negedge clk_i);
    start_i    <= 1'b0;
    mode_i     <= MODE_W'($urandom_range(3, 0));
    id_value_i <= {$urandom, $urandom};
  endtask

  // Present one request, hold it until accepted, then record it
  task automatic send_request(logic [MODE_W-1:0] mode, logic [RESULT_W-1:0] id);
    while ($urandom_range(99, 0) < idle_pct) idle_cycle();
    @(negedge clk_i);
    start_i    <= 1'b1;
    mode_i     <= mode;
    id_value_i <= id;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    tracker.note_request(mode, id);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // Pick an id: a narrow pool for repeats and matches, wide values, or edges
  function automatic logic [RESULT_W-1:0] pick_id(int unsigned style);
    logic [RESULT_W-1:0] val;
    case (style)
      0: val = RESULT_W'($urandom_range(5, 0));
      1: val = {$urandom, $urandom};
      default: begin
        case ($urandom_range(4, 0))
          0: val = '0;
          1: val = '1;
          2: val = {1'b1, {(RESULT_W-1){1'b0}}};
          3: val = RESULT_W'($urandom_range(3, 0));
          default: val = {$urandom, $urandom};
        endcase
      end
    endcase
    return val;
  endfunction

  // Load two lists in random interleaved order with occasional unused requests, then run
  task automatic list_pair(int unsigned a_len, int unsigned b_len, int unsigned style);
    int unsigned a_left;
    int unsigned b_left;
    a_left = a_len;
    b_left = b_len;
    while (a_left + b_left > 0) begin
      if ($urandom_range(19, 0) == 0) send_request(MODE_UNUSED, {$urandom, $urandom});
      if (b_left == 0 || (a_left > 0 && $urandom_range(1, 0) == 0)) begin
        send_request(MODE_LOAD_A, pick_id(style));
        a_left--;
      end else begin
        send_request(MODE_LOAD_B, pick_id(style));
        b_left--;
      end
    end
    send_request(MODE_RUN, {$urandom, $urandom});
  endtask

  initial begin
    int unsigned kind;
    tracker     = new();
    cycle_count = 0;
    items_sent  = 0;
    idle_pct    = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    mode_i      = MODE_LOAD_A;
    id_value_i  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Run on two empty lists: one empty result
    send_request(MODE_RUN, '0);
    // Extremes, duplicates, a match on all-ones and an ignored unused mode
    send_request(MODE_LOAD_A, '1);
    send_request(MODE_LOAD_A, '0);
    send_request(MODE_LOAD_A, 64'd5);
    send_request(MODE_LOAD_A, 64'd5);
    send_request(MODE_LOAD_A, 64'd5);
    send_request(MODE_LOAD_B, 64'd5);
    send_request(MODE_LOAD_B, 64'h8000_0000_0000_0000);
    send_request(MODE_LOAD_B, '1);
    send_request(MODE_UNUSED, '1);
    send_request(MODE_RUN, '1);
    // Fully cancelled by extra copies in the second list
    send_request(MODE_LOAD_A, 64'd9);
    send_request(MODE_LOAD_B, 64'd9);
    send_request(MODE_LOAD_B, 64'd9);
    send_request(MODE_RUN, 64'h5555_5555_5555_5555);
    // First list empty, second not
    send_request(MODE_LOAD_B, 64'd3);
    send_request(MODE_RUN, 64'hAAAA_AAAA_AAAA_AAAA);
    // Loaded out of order, top bit set
    send_request(MODE_LOAD_A, 64'h8000_0000_0000_0001);
    send_request(MODE_LOAD_A, 64'd1);
    send_request(MODE_RUN, '0);

    // Start the random part with full lists so overflow is always reached
    items_sent = 0;
    list_pair($urandom_range(35, 33), $urandom_range(34, 30), 0);

    // Random part: sender idle rate steps through the phases
    while (items_sent < RANDOM_ITEMS) begin
      case (items_sent * 4 / RANDOM_ITEMS)
        0: idle_pct = 0;
        1: idle_pct = 75;
        2: idle_pct = 0;
        default: idle_pct = 19;
      endcase
      kind = $urandom_range(99, 0);
      if (kind < 70) begin
        list_pair($urandom_range(8, 0), $urandom_range(8, 0), $urandom_range(2, 0));
      end else if (kind < 78) begin
        list_pair($urandom_range(34, 28), $urandom_range(34, 26), $urandom_range(2, 0));
      end else if (kind < 90) begin
        // One list only
        if ($urandom_range(1, 0)) list_pair($urandom_range(6, 1), 0, $urandom_range(2, 0));
        else list_pair(0, $urandom_range(6, 1), $urandom_range(2, 0));
      end else begin
        // Unused-mode noise followed by a bare run
        repeat ($urandom_range(3, 1)) send_request(MODE_UNUSED, {$urandom, $urandom});
        send_request(MODE_RUN, {$urandom, $urandom});
      end
    end

    // Release start, wait for the last results, then let the block settle
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tracker.pending_diff.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (tracker.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/smd_pkg.sv
hw/rtl/sorted_multiset_difference_top.sv
hw/rtl/smd_checker.sv
tb/tb_sorted_multiset_difference_top.sv
